// File: hw/rtl/ps2ma_pkg.sv
// Shared types and constants for the PS/2 mouse packet accumulator.
`default_nettype none

package ps2ma_pkg;

	// Default width of the running motion sums
	localparam int unsigned ACC_WIDTH_DEF = 16;

	// Width of the reported motion fields
	localparam int unsigned MOTION_W = 16;

	// Button field width and mask (left, right, middle)
	localparam int unsigned BTN_W = 3;
	localparam logic [BTN_W-1:0] BTN_MASK = 3'h7;

	// Input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Report kinds
	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Packet byte phases; any other value is the last byte of the packet
	localparam logic [1:0] PHASE_HEADER = 2'd0;
	localparam logic [1:0] PHASE_DX     = 2'd1;
	localparam logic [1:0] PHASE_DY     = 2'd2;

	// One input transaction
	typedef struct packed {
		logic       cmd;
		logic       aux_flag;
		logic [7:0] data_byte;
	} item_t;

	// One report
	typedef struct packed {
		logic                report_kind;
		logic [MOTION_W-1:0] motion_x;
		logic [MOTION_W-1:0] motion_y;
		logic [BTN_W-1:0]    button_state;
		logic [BTN_W-1:0]    pressed_mask;
		logic [BTN_W-1:0]    released_mask;
	} report_t;

endpackage

`default_nettype wire

// File: hw/rtl/ps2_mouse_packet_accumulator.sv
// Registered path: the input register, then the report register.
// Throughput: one transaction per cycle unless a due report meets a full slot; the input
// and report registers let a byte that yields no report pass a waiting report.
// Reset: arst_n clears the packet phase, buttons, sticky masks, sums and valid flags.
// A read command yields one report; the third aux byte of a packet yields one report.
`default_nettype none

module ps2_mouse_packet_accumulator #(
	parameter int unsigned ACC_WIDTH = ps2ma_pkg::ACC_WIDTH_DEF
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire  logic [1:0]  s_axis_tuser,  // [0] cmd, [1] aux_flag
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	// [15:0] motion_x, [31:16] motion_y, [34:32] button_state,
	// [37:35] pressed_mask, [40:38] released_mask, [47:41] zero
	output logic [47:0]       m_axis_tdata,
	output logic              m_axis_tuser   // report_kind
);

	ps2ma_pkg::item_t   item_s1;
	logic               valid_s1;
	ps2ma_pkg::report_t rpt;
	ps2ma_pkg::report_t rpt_q;
	logic               has_rpt;
	logic               out_free;
	logic               go_s1;
	logic               in_fire;

	// Stage advance: free when no report is due or the report slot opens
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign go_s1         = valid_s1 && (!has_rpt || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.cmd       <= s_axis_tuser[0];
			item_s1.aux_flag  <= s_axis_tuser[1];
			item_s1.data_byte <= s_axis_tdata;
		end
	end

	ps2ma_core #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (go_s1),
		.item      (item_s1),
		.has_report(has_rpt),
		.report    (rpt)
	);

	// Report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (go_s1 && has_rpt) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && has_rpt) begin
			rpt_q <= rpt;
		end
	end

	assign m_axis_tuser = rpt_q.report_kind;
	assign m_axis_tdata = {7'd0, rpt_q.released_mask, rpt_q.pressed_mask,
		rpt_q.button_state, rpt_q.motion_y, rpt_q.motion_x};

endmodule

`default_nettype wire

// File: hw/rtl/ps2ma_core.sv
// Packet phase tracking, button edge detection and saturating motion sums.
`default_nettype none

module ps2ma_core #(
	parameter int unsigned ACC_WIDTH = ps2ma_pkg::ACC_WIDTH_DEF
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic take,
	input  wire  ps2ma_pkg::item_t   item,
	output logic                     has_report,
	output ps2ma_pkg::report_t       report
);

	localparam int unsigned BW = ps2ma_pkg::BTN_W;
	localparam int unsigned MW = ps2ma_pkg::MOTION_W;

	logic [1:0]           phase_q;
	logic [7:0]           header_q;
	logic [7:0]           dx_q;
	logic [BW-1:0]        button_q;
	logic [BW-1:0]        pressed_q;
	logic [BW-1:0]        released_q;
	logic [ACC_WIDTH-1:0] sum_x_q;
	logic [ACC_WIDTH-1:0] sum_y_q;

	logic          is_read;
	logic          is_aux;
	logic          last_byte;
	logic [8:0]    dx9;
	logic [8:0]    ny9;
	logic [BW-1:0] new_btn;
	logic [BW-1:0] pr;
	logic [BW-1:0] rl;
	logic [ACC_WIDTH:0]    add_x;
	logic [ACC_WIDTH:0]    add_y;
	logic [ACC_WIDTH-1:0]  sat_x;
	logic [ACC_WIDTH-1:0]  sat_y;
	logic [ACC_WIDTH+MW-1:0] ext_x;
	logic [ACC_WIDTH+MW-1:0] ext_y;

	localparam logic [ACC_WIDTH-1:0] SUM_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] SUM_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	// Decode the transaction
	assign is_read   = (item.cmd == ps2ma_pkg::CMD_READ);
	assign is_aux    = (item.cmd == ps2ma_pkg::CMD_BYTE) && item.aux_flag;
	assign last_byte = (phase_q != ps2ma_pkg::PHASE_HEADER) &&
		(phase_q != ps2ma_pkg::PHASE_DX);
	assign has_report = is_read || (is_aux && last_byte);

	// Packet motion: dx as sent, dy negated (9 bits holds +128)
	assign dx9 = {dx_q[7], dx_q};
	assign ny9 = 9'd0 - {item.data_byte[7], item.data_byte};

	// Button edges against the previous packet
	assign new_btn = header_q[BW-1:0] & ps2ma_pkg::BTN_MASK;
	assign pr      = new_btn & ~button_q;
	assign rl      = button_q & ~new_btn;

	// Saturating sums: overflow when the two top bits of the wide sum differ
	assign add_x = {sum_x_q[ACC_WIDTH-1], sum_x_q} +
		{{(ACC_WIDTH-8){dx9[8]}}, dx9};
	assign add_y = {sum_y_q[ACC_WIDTH-1], sum_y_q} +
		{{(ACC_WIDTH-8){ny9[8]}}, ny9};

	always_comb begin
		if (add_x[ACC_WIDTH] != add_x[ACC_WIDTH-1]) begin
			sat_x = add_x[ACC_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sat_x = add_x[ACC_WIDTH-1:0];
		end
		if (add_y[ACC_WIDTH] != add_y[ACC_WIDTH-1]) begin
			sat_y = add_y[ACC_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sat_y = add_y[ACC_WIDTH-1:0];
		end
	end

	// Sums reported as their low bits after sign extension
	assign ext_x = {{MW{sum_x_q[ACC_WIDTH-1]}}, sum_x_q};
	assign ext_y = {{MW{sum_y_q[ACC_WIDTH-1]}}, sum_y_q};

	// Report contents
	always_comb begin
		if (is_read) begin
			report.report_kind   = ps2ma_pkg::KIND_READ;
			report.motion_x      = ext_x[MW-1:0];
			report.motion_y      = ext_y[MW-1:0];
			report.button_state  = button_q;
			report.pressed_mask  = pressed_q;
			report.released_mask = released_q;
		end else begin
			report.report_kind   = ps2ma_pkg::KIND_PACKET;
			report.motion_x      = {{(MW-9){dx9[8]}}, dx9};
			report.motion_y      = {{(MW-9){ny9[8]}}, ny9};
			report.button_state  = new_btn;
			report.pressed_mask  = pr;
			report.released_mask = rl;
		end
	end

	// State update per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ps2ma_pkg::PHASE_HEADER;
			header_q   <= '0;
			dx_q       <= '0;
			button_q   <= '0;
			pressed_q  <= '0;
			released_q <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
		end else if (take) begin
			if (is_read) begin
				sum_x_q    <= '0;
				sum_y_q    <= '0;
				pressed_q  <= '0;
				released_q <= '0;
			end else if (is_aux) begin
				case (phase_q)
					ps2ma_pkg::PHASE_HEADER: begin
						header_q <= item.data_byte;
						phase_q  <= ps2ma_pkg::PHASE_DX;
					end
					ps2ma_pkg::PHASE_DX: begin
						dx_q    <= item.data_byte;
						phase_q <= ps2ma_pkg::PHASE_DY;
					end
					default: begin
						sum_x_q    <= sat_x;
						sum_y_q    <= sat_y;
						pressed_q  <= pressed_q | pr;
						released_q <= released_q | rl;
						button_q   <= new_btn;
						phase_q    <= ps2ma_pkg::PHASE_HEADER;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_ps2_mouse_packet_accumulator.sv
// Self-checking testbench for the PS/2 mouse packet accumulator stream block.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_accumulator;

	localparam int ACC_W = ps2ma_pkg::ACC_WIDTH_DEF;
	localparam int MW    = ps2ma_pkg::MOTION_W;
	localparam int BW    = ps2ma_pkg::BTN_W;

	// Short names for the codes used in the stimulus table
	localparam logic BY = ps2ma_pkg::CMD_BYTE;
	localparam logic RD = ps2ma_pkg::CMD_READ;
	localparam logic KP = ps2ma_pkg::KIND_PACKET;
	localparam logic KR = ps2ma_pkg::KIND_READ;

	// Directed stimulus row; the expected report is typed in only where it is obvious
	typedef struct packed {
		logic          cmd;
		logic          aux;
		logic [7:0]    data;
		bit            typed;
		logic          kind;
		logic [MW-1:0] mx;
		logic [MW-1:0] my;
		logic [BW-1:0] btn;
		logic [BW-1:0] pr;
		logic [BW-1:0] rl;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [1:0]  s_axis_tuser;   // [0] cmd, [1] aux_flag
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [15:0] x, [31:16] y, [34:32] btn, [37:35] pr, [40:38] rl
	logic        m_axis_tuser;   // report_kind

	// Mouse state mirror
	logic [1:0]    pkt_phase;
	logic [7:0]    hdr_q;
	logic [7:0]    dx_q;
	logic [BW-1:0] btn_q;
	logic [BW-1:0] pressed_acc;
	logic [BW-1:0] released_acc;
	longint        sum_x_acc;
	longint        sum_y_acc;

	ps2ma_pkg::report_t expected_reports[$];

	int  mismatch_count;
	int  reports_checked;
	int  items_sent;
	int  items_ignored;
	int  sat_hits;
	bit  tx_idle_on;
	bit  rx_idle_on;
	int  rx_hold_left;

	dir_row_t dir_table [0:21] = '{
		// read right after reset: everything zero
		'{RD, 1'b0, 8'h00, 1'b1, KR, 16'h0000, 16'h0000, 3'h0, 3'h0, 3'h0},
		// byte from the keyboard port is ignored
		'{BY, 1'b0, 8'hFF, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h07, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h80, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		// ignored byte in the middle of a packet
		'{BY, 1'b0, 8'h5A, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		// most negative dx and dy, all buttons pressed
		'{BY, 1'b1, 8'h80, 1'b1, KP, 16'hFF80, 16'h0080, 3'h7, 3'h7, 3'h0},
		// header with only upper bits set: all buttons released
		'{BY, 1'b1, 8'hF8, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h7F, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h7F, 1'b1, KP, 16'h007F, 16'hFF81, 3'h0, 3'h0, 3'h7},
		// read with aux and data set: they must not matter
		'{RD, 1'b1, 8'hFF, 1'b1, KR, 16'hFFFF, 16'h0001, 3'h0, 3'h7, 3'h7},
		// second read sees cleared totals
		'{RD, 1'b0, 8'h00, 1'b1, KR, 16'h0000, 16'h0000, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h01, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h00, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h00, 1'b1, KP, 16'h0000, 16'h0000, 3'h1, 3'h1, 3'h0},
		'{BY, 1'b1, 8'h06, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'hFF, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h01, 1'b1, KP, 16'hFFFF, 16'hFFFF, 3'h6, 3'h6, 3'h1},
		'{BY, 1'b1, 8'h02, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'h01, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{BY, 1'b1, 8'hFE, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		'{RD, 1'b0, 8'hA5, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0},
		// stray byte: packet framing slips by one
		'{BY, 1'b1, 8'h80, 1'b0, KP, 16'h0, 16'h0, 3'h0, 3'h0, 3'h0}
	};

	ps2_mouse_packet_accumulator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic ps2ma_pkg::item_t make_item(logic cmd, logic aux, logic [7:0] b);
		ps2ma_pkg::item_t it;
		it.cmd = cmd;
		it.aux_flag = aux;
		it.data_byte = b;
		return it;
	endfunction

	function automatic longint clamp_sum(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (ACC_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat_hits++;
			return hi;
		end
		if (v < lo) begin
			sat_hits++;
			return lo;
		end
		return v;
	endfunction

	// Advance the mouse state by one transaction; returns 1 when a report is due
	function automatic bit mouse_predict(input ps2ma_pkg::item_t it,
		output ps2ma_pkg::report_t rep);
		longint dx_v;
		longint ny_v;
		logic [BW-1:0] nb;
		rep = '0;
		if (it.cmd == ps2ma_pkg::CMD_READ) begin
			rep.report_kind = ps2ma_pkg::KIND_READ;
			rep.motion_x = sum_x_acc[MW-1:0];
			rep.motion_y = sum_y_acc[MW-1:0];
			rep.button_state = btn_q;
			rep.pressed_mask = pressed_acc;
			rep.released_mask = released_acc;
			sum_x_acc = 0;
			sum_y_acc = 0;
			pressed_acc = '0;
			released_acc = '0;
			return 1'b1;
		end
		if (!it.aux_flag)
			return 1'b0;
		case (pkt_phase)
			ps2ma_pkg::PHASE_HEADER: begin
				hdr_q = it.data_byte;
				pkt_phase = ps2ma_pkg::PHASE_DX;
				return 1'b0;
			end
			ps2ma_pkg::PHASE_DX: begin
				dx_q = it.data_byte;
				pkt_phase = ps2ma_pkg::PHASE_DY;
				return 1'b0;
			end
			default: begin
				// third byte (and the unreachable fourth phase) closes the packet
				dx_v = $signed(dx_q);
				ny_v = $signed(it.data_byte);
				ny_v = -ny_v;
				nb = hdr_q[BW-1:0] & ps2ma_pkg::BTN_MASK;
				rep.report_kind = ps2ma_pkg::KIND_PACKET;
				rep.motion_x = dx_v[MW-1:0];
				rep.motion_y = ny_v[MW-1:0];
				rep.button_state = nb;
				rep.pressed_mask = nb & ~btn_q;
				rep.released_mask = btn_q & ~nb;
				sum_x_acc = clamp_sum(sum_x_acc + dx_v);
				sum_y_acc = clamp_sum(sum_y_acc + ny_v);
				pressed_acc = pressed_acc | rep.pressed_mask;
				released_acc = released_acc | rep.released_mask;
				btn_q = nb;
				pkt_phase = ps2ma_pkg::PHASE_HEADER;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic log_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offer one transaction, wait for acceptance, then record what it should produce
	task automatic offer_item(input ps2ma_pkg::item_t it, input bit typed = 1'b0,
		input ps2ma_pkg::report_t typed_rep = '0);
		ps2ma_pkg::report_t rep;
		bit                 has_rep;
		if (tx_idle_on) begin
			while ($urandom_range(99) < 17) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it.data_byte;
		s_axis_tuser <= {it.aux_flag, it.cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		has_rep = mouse_predict(it, rep);
		if (has_rep)
			expected_reports.push_back(typed ? typed_rep : rep);
		items_sent++;
		if (it.cmd == ps2ma_pkg::CMD_BYTE && !it.aux_flag)
			items_ignored++;
	endtask

	// Sender pause until every report has come out
	task automatic wait_reports_done(input int max_cycles);
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0 && n < max_cycles) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Aligned packets with large motion of one sign, to drive the sums into saturation
	task automatic drive_motion_run(input int packets, input bit negative);
		logic [7:0] base;
		base = negative ? 8'h80 : 8'h78;
		while (pkt_phase != ps2ma_pkg::PHASE_HEADER)
			offer_item(make_item(BY, 1'b1, 8'($urandom_range(255))));
		for (int p = 0; p < packets; p++) begin
			offer_item(make_item(BY, 1'b1, 8'($urandom_range(255))));
			offer_item(make_item(BY, 1'b1, base + 8'($urandom_range(7))));
			offer_item(make_item(BY, 1'b1, base + 8'($urandom_range(7))));
		end
		offer_item(make_item(RD, 1'($urandom_range(1)), 8'($urandom_range(255))));
	endtask

	// Receiver: random back-pressure, or a counted hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_left--;
			end else if (rx_idle_on) begin
				m_axis_tready <= ($urandom_range(99) >= 17);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Report checker
	always @(posedge clk) begin
		ps2ma_pkg::report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				log_mismatch("report with nothing expected, tdata", m_axis_tdata, 0);
			end else begin
				want = expected_reports.pop_front();
				if (m_axis_tuser !== want.report_kind)
					log_mismatch("report_kind", m_axis_tuser, want.report_kind);
				if (m_axis_tdata[15:0] !== want.motion_x)
					log_mismatch("motion_x", m_axis_tdata[15:0], want.motion_x);
				if (m_axis_tdata[31:16] !== want.motion_y)
					log_mismatch("motion_y", m_axis_tdata[31:16], want.motion_y);
				if (m_axis_tdata[34:32] !== want.button_state)
					log_mismatch("button_state", m_axis_tdata[34:32], want.button_state);
				if (m_axis_tdata[37:35] !== want.pressed_mask)
					log_mismatch("pressed_mask", m_axis_tdata[37:35], want.pressed_mask);
				if (m_axis_tdata[40:38] !== want.released_mask)
					log_mismatch("released_mask", m_axis_tdata[40:38], want.released_mask);
			end
			reports_checked++;
		end
	end

	// Main sequence
	initial begin
		ps2ma_pkg::report_t typed_rep;
		dir_row_t row;
		int r;
		int counted;
		int drain_n;

		pkt_phase = ps2ma_pkg::PHASE_HEADER;
		hdr_q = '0;
		dx_q = '0;
		btn_q = '0;
		pressed_acc = '0;
		released_acc = '0;
		sum_x_acc = 0;
		sum_y_acc = 0;
		mismatch_count = 0;
		reports_checked = 0;
		items_sent = 0;
		items_ignored = 0;
		sat_hits = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_left = 0;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_table[i]) begin
			row = dir_table[i];
			typed_rep.report_kind = row.kind;
			typed_rep.motion_x = row.mx;
			typed_rep.motion_y = row.my;
			typed_rep.button_state = row.btn;
			typed_rep.pressed_mask = row.pr;
			typed_rep.released_mask = row.rl;
			offer_item(make_item(row.cmd, row.aux, row.data), row.typed, typed_rep);
		end
		wait_reports_done(2000);

		// Long stretch with no idling on either side, starting with an output hold-off
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_left = 120;
		for (int k = 0; k < 16; k++)
			offer_item(make_item(RD, 1'($urandom_range(1)), 8'($urandom_range(255))));

		// Random traffic: mostly framed packets, some reads, stray and ignored bytes
		counted = 0;
		while (counted < 280) begin
			if (counted >= 80) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 70) begin
				for (int b = 0; b < 3; b++) begin
					if ($urandom_range(9) == 0)
						offer_item(make_item(BY, 1'b0, 8'($urandom_range(255))));
					offer_item(make_item(BY, 1'b1, 8'($urandom_range(255))));
				end
				counted += 3;
			end else if (r < 82) begin
				offer_item(make_item(RD, 1'($urandom_range(1)),
					8'($urandom_range(255))));
				counted++;
			end else if (r < 92) begin
				offer_item(make_item(BY, 1'b1, 8'($urandom_range(255))));
				counted++;
			end else begin
				offer_item(make_item(BY, 1'b0, 8'($urandom_range(255))));
			end
		end

		// Drive x up to its top limit and y down to its bottom limit
		wait_reports_done(2000);
		drive_motion_run(280, 1'b0);

		// Drain and finish
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		drain_n = 0;
		while (expected_reports.size() != 0 && drain_n < 5000) begin
			@(posedge clk);
			drain_n++;
		end
		repeat (10) @(posedge clk);
		if (expected_reports.size() != 0)
			log_mismatch("reports never delivered", 0, expected_reports.size());

		$display("Sent %0d transactions (%0d non-aux bytes ignored), checked %0d reports.",
			items_sent, items_ignored, reports_checked);
		$display("Covered framing slips, read-and-clear, %0d saturating additions, output stall.",
			sat_hits);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
